[rtl/cpv_pkg.sv]
package cpv_pkg;

  // Verdict codes carried on the result channel.
  typedef enum logic [1:0] {
    VERDICT_OK       = 2'd0,
    VERDICT_BAD_CODE = 2'd1,
    VERDICT_BAD_UTF8 = 2'd2
  } verdict_t;

  // Position inside the payload, one-hot.
  typedef enum logic [2:0] {
    POS_CODE_HI = 3'b001,
    POS_CODE_LO = 3'b010,
    POS_TEXT    = 3'b100
  } pos_t;

  // Close code limits.
  localparam logic [15:0] CODE_MIN      = 16'd1000;
  localparam logic [15:0] CODE_RSV1_LO  = 16'd1004;
  localparam logic [15:0] CODE_RSV1_HI  = 16'd1006;
  localparam logic [15:0] CODE_RSV2_LO  = 16'd1012;
  localparam logic [15:0] CODE_RSV2_HI  = 16'd2999;

  // UTF-8 start and continuation byte classes.
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] PAT_CONT   = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] PAT_LEAD4  = 8'hF0;
  localparam logic [7:0] MASK_ASCII = 8'h80;

  // Reason text decoder state.
  typedef struct packed {
    logic [1:0] pending;
    logic       failed;
  } utf8_st_t;

endpackage

[rtl/cpv_if.sv]
interface cpv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;
  logic       empty_payload;

  modport source (output valid, output payload_byte, output last_byte,
                  output empty_payload, input ready);
  modport sink   (input valid, input payload_byte, input last_byte,
                  input empty_payload, output ready);
endinterface

interface cpv_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

[rtl/cpv_code_check.sv]
module cpv_code_check
  import cpv_pkg::*;
(
  input  logic [15:0] code,
  output logic        rejected
);

  // Reject codes below the minimum and the two reserved ranges.
  assign rejected = (code < CODE_MIN) ||
                    ((code >= CODE_RSV1_LO) && (code <= CODE_RSV1_HI)) ||
                    ((code >= CODE_RSV2_LO) && (code <= CODE_RSV2_HI));

endmodule

[rtl/cpv_utf8_step.sv]
module cpv_utf8_step
  import cpv_pkg::*;
(
  input  utf8_st_t   st,
  input  logic [7:0] data,
  output utf8_st_t   st_nxt
);

  always_comb begin
    st_nxt = st;
    if (!st.failed) begin
      if (st.pending != 2'd0) begin
        // A continuation byte is due.
        if ((data & MASK_CONT) != PAT_CONT) begin
          st_nxt.failed = 1'b1;
        end else begin
          st_nxt.pending = st.pending - 2'd1;
        end
      end else if ((data & MASK_ASCII) == 8'h00) begin
        st_nxt = st;
      end else if ((data & MASK_LEAD2) == PAT_LEAD2) begin
        st_nxt.pending = 2'd1;
      end else if ((data & MASK_LEAD3) == PAT_LEAD3) begin
        st_nxt.pending = 2'd2;
      end else if ((data & MASK_LEAD4) == PAT_LEAD4) begin
        st_nxt.pending = 2'd3;
      end else begin
        st_nxt.failed = 1'b1;
      end
    end
  end

endmodule

[rtl/close_payload_validator.sv]
// Close-frame payload validator. Payload bytes enter one request per cycle on
// in_ch while in_ch.ready is high, the final byte flagged by last_byte; a
// request with empty_payload set stands for a zero-length payload. Each
// payload yields exactly one verdict request on out_ch: ok, invalid close
// code, or invalid UTF-8 in the reason text. The first two bytes form a
// big-endian close code; the remaining bytes are checked against start-byte
// classes and 10xxxxxx continuation bytes, and a sequence left open at the end
// is invalid. A close-code error wins over a text error. The block sustains
// one input request per clock cycle unless the input side is held off. A
// request is captured in an input register when accepted; the per-byte state
// update and the verdict are worked out combinationally from that register,
// and the verdict is loaded into the output register when the request retires
// and is offered on out_ch from there. Input and output stay decoupled: a new
// byte is taken while a verdict waits, and only a payload-ending request in
// the input register facing a full, stalled output register holds off the
// input side.
module close_payload_validator
  import cpv_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  cpv_in_if.sink    in_ch,
  cpv_out_if.source out_ch
);

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_empty_r;

  // Per-payload state.
  pos_t       pos_r, pos_nxt;
  logic [7:0] code_hi_r, code_hi_nxt;
  logic       code_failed_r, code_failed_nxt;
  utf8_st_t   utf8_r, utf8_nxt;

  // Output register.
  logic       out_valid_r;
  verdict_t   verdict_r;

  logic       s1_has_res;
  logic       out_free;
  logic       s1_fire;
  logic       in_fire;
  logic       rejected;
  utf8_st_t   utf8_step;
  verdict_t   verdict_c;

  // A request that ends a payload needs a free output slot; any other request
  // only updates the state and may retire unconditionally.
  assign s1_has_res = s1_empty_r || s1_last_r;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign s1_fire    = s1_valid_r && (!s1_has_res || out_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_ch.payload_byte;
      s1_last_r  <= in_ch.last_byte;
      s1_empty_r <= in_ch.empty_payload;
    end
  end

  cpv_code_check u_code_check (
    .code     ({code_hi_r, s1_byte_r}),
    .rejected (rejected)
  );

  cpv_utf8_step u_utf8_step (
    .st     (utf8_r),
    .data   (s1_byte_r),
    .st_nxt (utf8_step)
  );

  // State update and verdict for the request held in the input register.
  always_comb begin
    pos_nxt         = pos_r;
    code_hi_nxt     = code_hi_r;
    code_failed_nxt = code_failed_r;
    utf8_nxt        = utf8_r;
    verdict_c       = VERDICT_OK;

    if (s1_empty_r) begin
      verdict_c       = VERDICT_OK;
      pos_nxt         = POS_CODE_HI;
      code_failed_nxt = 1'b0;
      utf8_nxt        = '0;
    end else begin
      unique case (pos_r)
        POS_CODE_HI: begin
          code_hi_nxt = s1_byte_r;
          verdict_c   = VERDICT_BAD_CODE;
          pos_nxt     = s1_last_r ? POS_CODE_HI : POS_CODE_LO;
        end
        POS_CODE_LO: begin
          code_failed_nxt = rejected;
          verdict_c       = rejected ? VERDICT_BAD_CODE : VERDICT_OK;
          pos_nxt         = POS_TEXT;
        end
        POS_TEXT: begin
          utf8_nxt = utf8_step;
          if (code_failed_r) begin
            verdict_c = VERDICT_BAD_CODE;
          end else if (utf8_step.failed || (utf8_step.pending != 2'd0)) begin
            verdict_c = VERDICT_BAD_UTF8;
          end else begin
            verdict_c = VERDICT_OK;
          end
        end
        default: begin
          pos_nxt = POS_CODE_HI;
        end
      endcase

      // The final byte closes the payload and clears the state.
      if (s1_last_r) begin
        pos_nxt         = POS_CODE_HI;
        code_failed_nxt = 1'b0;
        utf8_nxt        = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= POS_CODE_HI;
      code_failed_r <= 1'b0;
      utf8_r        <= '0;
    end else if (s1_fire) begin
      pos_r         <= pos_nxt;
      code_failed_r <= code_failed_nxt;
      utf8_r        <= utf8_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      code_hi_r <= code_hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_has_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_has_res) begin
      verdict_r <= verdict_c;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.verdict = verdict_r;

  // The reserved verdict code never leaves the block.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.verdict == VERDICT_OK ||
                      out_ch.verdict == VERDICT_BAD_CODE ||
                      out_ch.verdict == VERDICT_BAD_UTF8))
    else $error("verdict carries a reserved code");

  // At the start of a payload no text or code error may be left over.
  assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == POS_CODE_HI) |-> (utf8_r == '0 && !code_failed_r))
    else $error("stale payload state at payload start");

  // Continuation bytes are only outstanding inside the reason text.
  assert property (@(posedge clk) disable iff (!rst_n)
    (utf8_r.pending != 2'd0) |-> (pos_r == POS_TEXT))
    else $error("pending continuations outside the reason text");

  // A request that cannot retire stays in the input register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> s1_valid_r)
    else $error("input register dropped a stalled request");

endmodule
